>>> rtl/wsg_pkg.sv
// ----------------------------------------------------------------------------
// wsg_pkg
// shared types, widths and constants of the wiener spectral gain core
// ----------------------------------------------------------------------------
package wsg_pkg;

    localparam int FRAME_LEN   = 512;
    localparam int NBINS       = FRAME_LEN / 2 + 1;
    localparam int BIN_W       = 9;
    localparam int DATA_W      = 24;
    localparam int SQ_W        = 2 * DATA_W - 1;
    localparam int POW_W       = 48;
    localparam int CNT_W       = 7;
    localparam int GAIN_W      = 17;
    localparam int CFG_W       = 48;
    localparam int CFG_IDX_W   = 2;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

    // learn divider: bits of quotient per stage
    localparam int LDIV_BITS   = 4;
    localparam int LDIV_STAGES = POW_W / LDIV_BITS;
    // gain divider: one quotient bit per stage
    localparam int GDIV_STAGES = GAIN_W;

    localparam int QDEPTH      = 32;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [CNT_W-1:0]  RST_FRAME_COUNT = CNT_W'(20);
    localparam logic [GAIN_W-1:0] RST_GAIN_FLOOR  = GAIN_W'(6554);
    localparam logic [POW_W-1:0]  RST_POWER_FLOOR = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COUNT = 2'd0,
        CFG_GAIN_FLOOR  = 2'd1,
        CFG_POWER_FLOOR = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        CMD_LEARN  = 1'b0,
        CMD_FILTER = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0]  frame_count;
        logic [GAIN_W-1:0] gain_floor;
        logic [POW_W-1:0]  power_floor;
    } cfg_t;

    // item in the front pipeline
    typedef struct packed {
        cmd_t                     cmd;
        logic [BIN_W-1:0]         bin;
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic [POW_W-1:0]         power;
        logic [CNT_W-1:0]         rem;
        logic [POW_W-1:0]         quo;
    } front_t;

    // filter item handed from front to back
    typedef struct packed {
        logic [BIN_W-1:0]         bin;
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic [POW_W-1:0]         power;
        logic [POW_W-1:0]         noise;
    } q_item_t;

    // item in the gain divider
    typedef struct packed {
        logic [BIN_W-1:0]         bin;
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic [POW_W-1:0]         power;
        logic [POW_W:0]           rem;
        logic [GAIN_W-1:0]        quo;
        logic                     zero;
    } back_t;

endpackage

>>> rtl/wsg_ram.sv
// ----------------------------------------------------------------------------
// wsg_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module wsg_ram #(
    parameter  int WIDTH = 48,
    parameter  int DEPTH = 257,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/wsg_front.sv
// ----------------------------------------------------------------------------
// wsg_front
// power, learn divider and noise table read-modify-write
// ----------------------------------------------------------------------------
module wsg_front import wsg_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     accept,
    input  logic                     command,
    input  logic [BIN_W-1:0]         bin_index,
    input  logic signed [DATA_W-1:0] re_in,
    input  logic signed [DATA_W-1:0] im_in,
    output logic                     push,
    output q_item_t                  push_item
);

    // square stage
    logic                     sq_vld_reg;
    cmd_t                     sq_cmd_reg;
    logic [BIN_W-1:0]         sq_bin_reg;
    logic signed [DATA_W-1:0] sq_re_reg;
    logic signed [DATA_W-1:0] sq_im_reg;
    logic [SQ_W-1:0]          sq_re2_reg;
    logic [SQ_W-1:0]          sq_im2_reg;
    logic signed [2*DATA_W-1:0] re_prod;
    logic signed [2*DATA_W-1:0] im_prod;

    // learn divider stages
    logic [LDIV_STAGES:0] ld_vld_reg;
    front_t               ld_reg  [LDIV_STAGES+1];
    front_t               ld_next [LDIV_STAGES];
    logic [CNT_W-1:0]     divisor;

    // table stage
    logic                 t_in_range;
    logic [BIN_W-1:0]     rd_addr;
    logic                 r_vld_reg;
    front_t               r_reg;
    logic                 r_in_range_reg;
    logic                 r_vbit_reg;
    logic                 r_fwd_reg;
    logic [POW_W-1:0]     fwd_data_reg;
    logic [POW_W-1:0]     rdata;
    logic [POW_W-1:0]     noise_cur;
    logic [POW_W:0]       sum;
    logic [POW_W-1:0]     wdata;
    logic                 we;
    logic [NBINS-1:0]     vbits_reg;

    assign re_prod = re_in * re_in;
    assign im_prod = im_in * im_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg <= 1'b0;
            ld_vld_reg <= '0;
            r_vld_reg  <= 1'b0;
            vbits_reg  <= '0;
        end
        else
        begin
            sq_vld_reg <= accept;
            ld_vld_reg <= {ld_vld_reg[LDIV_STAGES-1:0], sq_vld_reg};
            r_vld_reg  <= ld_vld_reg[LDIV_STAGES];
            if (we)
            begin
                vbits_reg[r_reg.bin] <= 1'b1;
            end
        end
    end

    assign divisor = (cfg.frame_count == '0) ? CNT_W'(1) : cfg.frame_count;

    // restoring division, LDIV_BITS quotient bits per stage
    always_comb
    begin
        logic [CNT_W:0] trial;
        for (int k = 0; k < LDIV_STAGES; k++)
        begin
            ld_next[k] = ld_reg[k];
            for (int j = 0; j < LDIV_BITS; j++)
            begin
                trial = {ld_next[k].rem, ld_next[k].power[POW_W-1-k*LDIV_BITS-j]};
                if (trial >= {1'b0, divisor})
                begin
                    ld_next[k].rem = CNT_W'(trial - {1'b0, divisor});
                    ld_next[k].quo[POW_W-1-k*LDIV_BITS-j] = 1'b1;
                end
                else
                begin
                    ld_next[k].rem = trial[CNT_W-1:0];
                end
            end
        end
    end

    assign t_in_range = (ld_reg[LDIV_STAGES].bin < BIN_W'(NBINS));
    assign rd_addr    = t_in_range ? ld_reg[LDIV_STAGES].bin : '0;

    always_ff @(posedge clk)
    begin
        sq_cmd_reg <= cmd_t'(command);
        sq_bin_reg <= bin_index;
        sq_re_reg  <= re_in;
        sq_im_reg  <= im_in;
        sq_re2_reg <= re_prod[SQ_W-1:0];
        sq_im2_reg <= im_prod[SQ_W-1:0];

        ld_reg[0].cmd   <= sq_cmd_reg;
        ld_reg[0].bin   <= sq_bin_reg;
        ld_reg[0].re    <= sq_re_reg;
        ld_reg[0].im    <= sq_im_reg;
        ld_reg[0].power <= {1'b0, sq_re2_reg} + {1'b0, sq_im2_reg};
        ld_reg[0].rem   <= '0;
        ld_reg[0].quo   <= '0;
        for (int k = 0; k < LDIV_STAGES; k++)
        begin
            ld_reg[k+1] <= ld_next[k];
        end

        r_reg          <= ld_reg[LDIV_STAGES];
        r_in_range_reg <= t_in_range;
        r_vbit_reg     <= t_in_range & vbits_reg[rd_addr];
        // entry written this cycle is not yet visible in the ram read
        r_fwd_reg      <= we && (r_reg.bin == ld_reg[LDIV_STAGES].bin);
        fwd_data_reg   <= wdata;
    end

    wsg_ram #(
        .WIDTH (POW_W),
        .DEPTH (NBINS)
    ) u_noise_ram (
        .clk   (clk),
        .we    (we),
        .waddr (r_reg.bin),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    assign noise_cur = r_fwd_reg  ? fwd_data_reg :
                       r_vbit_reg ? rdata : '0;
    assign sum       = {1'b0, noise_cur} + {1'b0, r_reg.quo};
    assign wdata     = sum[POW_W] ? {POW_W{1'b1}} : sum[POW_W-1:0];
    assign we        = r_vld_reg && (r_reg.cmd == CMD_LEARN) && r_in_range_reg;

    assign push            = r_vld_reg && (r_reg.cmd == CMD_FILTER);
    assign push_item.bin   = r_reg.bin;
    assign push_item.re    = r_reg.re;
    assign push_item.im    = r_reg.im;
    assign push_item.power = r_reg.power;
    assign push_item.noise = noise_cur;

endmodule

>>> rtl/wsg_queue.sv
// ----------------------------------------------------------------------------
// wsg_queue
// small fifo between the table stage and the gain pipeline
// ----------------------------------------------------------------------------
module wsg_queue import wsg_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    input  logic    pop,
    output logic    not_empty,
    output q_item_t head
);

    q_item_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

endmodule

>>> rtl/wsg_back.sv
// ----------------------------------------------------------------------------
// wsg_back
// gain divider, clamp and scaling of the bin
// ----------------------------------------------------------------------------
module wsg_back import wsg_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     q_valid,
    input  q_item_t                  q_head,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [BIN_W-1:0]         bin_out,
    output logic signed [DATA_W-1:0] re_out,
    output logic signed [DATA_W-1:0] im_out,
    output logic [GAIN_W-1:0]        gain_q16
);

    logic                 en;
    logic [GDIV_STAGES:0] gd_vld_reg;
    back_t                gd_reg  [GDIV_STAGES+1];
    back_t                gd_next [GDIV_STAGES];

    logic                     c_vld_reg;
    logic [BIN_W-1:0]         c_bin_reg;
    logic signed [DATA_W-1:0] c_re_reg;
    logic signed [DATA_W-1:0] c_im_reg;
    logic [GAIN_W-1:0]        c_gain_reg;
    logic [GAIN_W-1:0]        gain_raw;
    logic [GAIN_W-1:0]        gain_lo;
    logic [GAIN_W-1:0]        gain_cl;

    logic                     o_vld_reg;
    logic [BIN_W-1:0]         o_bin_reg;
    logic signed [DATA_W-1:0] o_re_reg;
    logic signed [DATA_W-1:0] o_im_reg;
    logic [GAIN_W-1:0]        o_gain_reg;
    logic signed [DATA_W+GAIN_W:0] re_prod;
    logic signed [DATA_W+GAIN_W:0] im_prod;

    // whole pipeline holds while the output item waits
    assign en  = !o_vld_reg || out_ready;
    assign pop = q_valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gd_vld_reg <= '0;
            c_vld_reg  <= 1'b0;
            o_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            gd_vld_reg <= {gd_vld_reg[GDIV_STAGES-1:0], q_valid};
            c_vld_reg  <= gd_vld_reg[GDIV_STAGES];
            o_vld_reg  <= c_vld_reg;
        end
    end

    // restoring division of clean * 2^16 by power, one bit per stage
    always_comb
    begin
        logic [POW_W:0] trial;
        for (int k = 0; k < GDIV_STAGES; k++)
        begin
            gd_next[k] = gd_reg[k];
            trial = (k == 0) ? gd_reg[k].rem : {gd_reg[k].rem[POW_W-1:0], 1'b0};
            if (trial >= {1'b0, gd_reg[k].power})
            begin
                gd_next[k].rem = trial - {1'b0, gd_reg[k].power};
                gd_next[k].quo[GAIN_W-1-k] = 1'b1;
            end
            else
            begin
                gd_next[k].rem = trial;
            end
        end
    end

    assign gain_raw = gd_reg[GDIV_STAGES].zero ? '0 :
                      (gd_reg[GDIV_STAGES].quo > GAIN_ONE) ? GAIN_ONE :
                      gd_reg[GDIV_STAGES].quo;
    assign gain_lo  = (cfg.gain_floor > GAIN_ONE) ? GAIN_ONE : cfg.gain_floor;
    assign gain_cl  = (gain_raw < gain_lo) ? gain_lo : gain_raw;

    assign re_prod = c_re_reg * $signed({1'b0, c_gain_reg});
    assign im_prod = c_im_reg * $signed({1'b0, c_gain_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gd_reg[0].bin   <= q_head.bin;
            gd_reg[0].re    <= q_head.re;
            gd_reg[0].im    <= q_head.im;
            gd_reg[0].power <= q_head.power;
            gd_reg[0].rem   <= (q_head.power > q_head.noise) ?
                               {1'b0, q_head.power - q_head.noise} : '0;
            gd_reg[0].quo   <= '0;
            gd_reg[0].zero  <= (q_head.power <= cfg.power_floor);
            for (int k = 0; k < GDIV_STAGES; k++)
            begin
                gd_reg[k+1] <= gd_next[k];
            end

            c_bin_reg  <= gd_reg[GDIV_STAGES].bin;
            c_re_reg   <= gd_reg[GDIV_STAGES].re;
            c_im_reg   <= gd_reg[GDIV_STAGES].im;
            c_gain_reg <= gain_cl;

            // floor of product / 2^16
            o_bin_reg  <= c_bin_reg;
            o_re_reg   <= re_prod[DATA_W+15:16];
            o_im_reg   <= im_prod[DATA_W+15:16];
            o_gain_reg <= c_gain_reg;
        end
    end

    assign out_valid = o_vld_reg;
    assign bin_out   = o_bin_reg;
    assign re_out    = o_re_reg;
    assign im_out    = o_im_reg;
    assign gain_q16  = o_gain_reg;

endmodule

>>> rtl/wiener_spectral_gain_core.sv
// ----------------------------------------------------------------------------
// wiener_spectral_gain_core
// per-bin wiener gain with noise learning and a lower gain clamp
// ----------------------------------------------------------------------------
// input channel: one spectral bin per item (command, bin_index, re_in, im_in)
// with in_valid / in_ready. a learn item adds power / frame_count to
// the bin's noise entry and gives no result; a filter item gives one result
// item (bin_out, re_out, im_out, gain_q16) on the out_valid / out_ready side.
// throughput: one item per cycle while in_ready is high, learn and filter
// mixed in any order; the front pipeline never stalls and a learn update is
// seen by any later item. a filter item passes in order through squaring at
// the accepting edge, the learn division stages and the noise table access,
// the item queue, forming the clean power, the gain division (one quotient
// bit per cycle while the output is not stalled), the clamp and the scaling
// multiply.
// when the receiver stalls, the gain pipeline holds and filter items pile up
// in a 32-entry queue; in_ready drops once 32 filter items are taken but not
// yet drained from the queue, so nothing is lost.
// reset clears all control state, the noise table (by per-entry valid flags,
// no clearing pass) and loads the default register values.
// the user writes registers through cfg_write / cfg_index / cfg_data only while idle; the core does not check.
// ----------------------------------------------------------------------------
module wiener_spectral_gain_core import wsg_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     command,
    input  logic [BIN_W-1:0]         bin_index,
    input  logic signed [DATA_W-1:0] re_in,
    input  logic signed [DATA_W-1:0] im_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [BIN_W-1:0]         bin_out,
    output logic signed [DATA_W-1:0] re_out,
    output logic signed [DATA_W-1:0] im_out,
    output logic [GAIN_W-1:0]        gain_q16
);

    cfg_t              cfg_reg;
    logic [QCNT_W-1:0] occ_reg;
    logic              accept;
    logic              push;
    q_item_t           push_item;
    logic              pop;
    logic              q_valid;
    q_item_t           q_head;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_count <= RST_FRAME_COUNT;
            cfg_reg.gain_floor  <= RST_GAIN_FLOOR;
            cfg_reg.power_floor <= RST_POWER_FLOOR;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FRAME_COUNT: cfg_reg.frame_count <= cfg_data[CNT_W-1:0];
                CFG_GAIN_FLOOR:  cfg_reg.gain_floor  <= cfg_data[GAIN_W-1:0];
                CFG_POWER_FLOOR: cfg_reg.power_floor <= cfg_data[POW_W-1:0];
                default:         ;
            endcase
        end
    end

    // credit count: filter items taken and not yet popped from the queue,
    // so the queue can always absorb what the front has in flight
    assign accept   = in_valid && in_ready;
    assign in_ready = (occ_reg < QCNT_W'(QDEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_reg + QCNT_W'(accept && (cmd_t'(command) == CMD_FILTER))
                       - QCNT_W'(pop);
        end
    end

    wsg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (accept),
        .command   (command),
        .bin_index (bin_index),
        .re_in     (re_in),
        .im_in     (im_in),
        .push      (push),
        .push_item (push_item)
    );

    wsg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    wsg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .bin_out   (bin_out),
        .re_out    (re_out),
        .im_out    (im_out),
        .gain_q16  (gain_q16)
    );

endmodule

>>> rtl/wsg_checker.sv
// ----------------------------------------------------------------------------
// wsg_checker
// port-level checks of the wiener spectral gain core
// ----------------------------------------------------------------------------
module wsg_checker import wsg_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [BIN_W-1:0]         bin_out,
    input logic signed [DATA_W-1:0] re_out,
    input logic signed [DATA_W-1:0] im_out,
    input logic [GAIN_W-1:0]        gain_q16
);

    // stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bin_out)
            && $stable(re_out) && $stable(im_out) && $stable(gain_q16))
        else $error("result item changed while stalled");

    // gain never above unity
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> gain_q16 <= GAIN_ONE)
        else $error("gain above one");

    // zero gain silences the bin
    a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gain_q16 == '0 |-> re_out == '0 && im_out == '0)
        else $error("nonzero output with zero gain");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result item right after reset");

endmodule

bind wiener_spectral_gain_core wsg_checker u_wsg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .bin_out   (bin_out),
    .re_out    (re_out),
    .im_out    (im_out),
    .gain_q16  (gain_q16)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the wiener spectral gain core: noise learning and
// filtering are predicted in the bench, results checked field by field under
// random source gaps and sink stalls across several register settings
// ----------------------------------------------------------------------------
module tb;
    import wsg_pkg::*;

    // one spectral bin as sent to the core
    typedef struct {
        cmd_t                     cmd;
        logic [BIN_W-1:0]         bin;
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } bin_item_t;

    // one filtered bin as produced by the core
    typedef struct {
        logic [BIN_W-1:0]         bin;
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic [GAIN_W-1:0]        gain;
    } filt_item_t;

    localparam int       CYCLE_LIMIT = 400000;
    localparam int       DRAIN_WAIT  = 60;
    localparam logic [POW_W-1:0] POW_MAX = {POW_W{1'b1}};

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic command;
    logic [BIN_W-1:0] bin_index;
    logic signed [DATA_W-1:0] re_in;
    logic signed [DATA_W-1:0] im_in;
    logic out_valid;
    logic out_ready;
    logic [BIN_W-1:0] bin_out;
    logic signed [DATA_W-1:0] re_out;
    logic signed [DATA_W-1:0] im_out;
    logic [GAIN_W-1:0] gain_q16;

    wiener_spectral_gain_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .bin_index (bin_index),
        .re_in     (re_in),
        .im_in     (im_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .bin_out   (bin_out),
        .re_out    (re_out),
        .im_out    (im_out),
        .gain_q16  (gain_q16)
    );

    // bench copy of the core's state and registers
    logic [POW_W-1:0]  noise_est [NBINS];
    logic [CNT_W-1:0]  frame_count;
    logic [GAIN_W-1:0] gain_floor;
    logic [POW_W-1:0]  power_floor;

    bin_item_t  pending_bins[$];
    filt_item_t expected_bins[$];

    int  errors;
    int  sent_items;
    int  filtered_seen;
    int  cycles;
    int  src_idle_pct;
    int  snk_stall_pct;
    bit  stim_done;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // product x * gain, shifted arithmetically right by 16 (floor)
    function automatic logic signed [DATA_W-1:0] apply_gain(
        logic signed [DATA_W-1:0] x, logic [GAIN_W-1:0] g);
        logic signed [63:0] prod;
        prod = 64'(x) * $signed({47'd0, g});
        return DATA_W'(prod >>> 16);
    endfunction

    // advance the noise table or work out the filtered bin
    function automatic bit predict_bin(bin_item_t it, output filt_item_t res);
        logic [63:0] mr, mi, pwr, noise, clean, gain, div, sum, gfloor;
        bit in_range;
        mr = (it.re < 0) ? 64'(-64'(it.re)) : 64'(it.re);
        mi = (it.im < 0) ? 64'(-64'(it.im)) : 64'(it.im);
        pwr = mr * mr + mi * mi;
        in_range = it.bin < NBINS;
        if (it.cmd == CMD_LEARN) begin
            // zero count divides as one; out of range bins leave no trace
            div = (frame_count == 0) ? 64'd1 : 64'(frame_count);
            if (in_range) begin
                sum = 64'(noise_est[it.bin]) + pwr / div;
                noise_est[it.bin] = (sum > 64'(POW_MAX)) ? POW_MAX : POW_W'(sum);
            end
            return 0;
        end
        noise = in_range ? 64'(noise_est[it.bin]) : 64'd0;
        clean = (pwr > noise) ? pwr - noise : 64'd0;
        // zero power always falls under the floor, so no divide by zero
        gain = (pwr <= 64'(power_floor)) ? 64'd0 : (clean << 16) / pwr;
        if (gain > 64'd65536)
            gain = 64'd65536;
        gfloor = (gain_floor > GAIN_ONE) ? 64'd65536 : 64'(gain_floor);
        if (gain < gfloor)
            gain = gfloor;
        res.bin  = it.bin;
        res.gain = GAIN_W'(gain);
        res.re   = apply_gain(it.re, res.gain);
        res.im   = apply_gain(it.im, res.gain);
        return 1;
    endfunction

    // ------------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_bins.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driver: pops the next pending item, holds it until taken
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        bin_item_t   nxt;
        filt_item_t  res;
        bit          load;
        if (!rst_n) begin
            in_valid  <= 1'b0;
            command   <= 1'b0;
            bin_index <= '0;
            re_in     <= '0;
            im_in     <= '0;
        end
        else begin
            load = 0;
            if (in_valid && in_ready) begin
                // item taken: predict it now, registers are stable during traffic
                nxt.cmd = cmd_t'(command);
                nxt.bin = bin_index;
                nxt.re  = re_in;
                nxt.im  = im_in;
                if (predict_bin(nxt, res))
                    expected_bins.push_back(res);
                sent_items <= sent_items + 1;
                load = 1;
            end
            else if (!in_valid)
                load = 1;
            if (load) begin
                if (pending_bins.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt = pending_bins.pop_front();
                    in_valid  <= 1'b1;
                    command   <= nxt.cmd;
                    bin_index <= nxt.bin;
                    re_in     <= nxt.re;
                    im_in     <= nxt.im;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each taken result against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        filt_item_t want;
        int         bad;
        if (!rst_n)
            out_ready <= 1'b0;
        else begin
            bad = 0;
            if (out_valid && out_ready) begin
                filtered_seen <= filtered_seen + 1;
                if (expected_bins.size() == 0) begin
                    $error("unexpected result item for bin %0d", bin_out);
                    bad = bad + 1;
                end
                else begin
                    want = expected_bins.pop_front();
                    if (bin_out !== want.bin) begin
                        $error("bin_out expected %0d got %0d", want.bin, bin_out);
                        bad = bad + 1;
                    end
                    if (re_out !== want.re) begin
                        $error("re_out expected %0d got %0d", want.re, re_out);
                        bad = bad + 1;
                    end
                    if (im_out !== want.im) begin
                        $error("im_out expected %0d got %0d", want.im, im_out);
                        bad = bad + 1;
                    end
                    if (gain_q16 !== want.gain) begin
                        $error("gain_q16 expected %0d got %0d", want.gain, gain_q16);
                        bad = bad + 1;
                    end
                end
            end
            if (bad != 0)
                errors <= errors + bad;
            out_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_bin(cmd_t c, int b, int r, int i);
        bin_item_t it;
        it.cmd = c;
        it.bin = BIN_W'(b);
        it.re  = DATA_W'(r);
        it.im  = DATA_W'(i);
        pending_bins.push_back(it);
    endtask

    // write a register while the core is idle; prediction follows at once
    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_FRAME_COUNT: frame_count = CNT_W'(val);
            CFG_GAIN_FLOOR:  gain_floor  = GAIN_W'(val);
            default:         power_floor = POW_W'(val);
        endcase
    endtask

    // everything sent, every result back, then the tail of the pipeline
    task automatic wait_idle();
        while (pending_bins.size() > 0 || in_valid || expected_bins.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic int rand_sample();
        case ($urandom_range(5))
            0:       return $urandom_range(255) - 128;
            1:       return $urandom_range(65535) - 32768;
            2:       return ($urandom_range(1)) ? 8388607 : -8388608;
            default: return int'($urandom_range(16777215)) - 8388608;
        endcase
    endfunction

    // mostly realistic bins: learn and filter items mixed at random, about two in five learn
    task automatic queue_random(int count);
        int k;
        int b;
        int r;
        int i;
        for (k = 0; k < count; k++) begin
            // bins concentrated on a handful so the table builds up
            b = ($urandom_range(19) == 0) ? $urandom_range(511) : $urandom_range(15) * 17;
            r = rand_sample();
            i = rand_sample();
            push_bin(($urandom_range(99) < 40) ? CMD_LEARN : CMD_FILTER, b, r, i);
        end
    endtask

    task automatic run_phase(int idle, int stall, int count);
        src_idle_pct  = idle;
        snk_stall_pct = stall;
        queue_random(count);
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int k;
        errors = 0;
        sent_items = 0;
        filtered_seen = 0;
        cycles = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_FRAME_COUNT;
        cfg_data = '0;
        for (k = 0; k < NBINS; k++)
            noise_est[k] = '0;
        frame_count = RST_FRAME_COUNT;
        gain_floor = RST_GAIN_FLOOR;
        power_floor = RST_POWER_FLOOR;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset defaults, zero power, extremes, edge bins
        push_bin(CMD_FILTER, 0, 0, 0);
        push_bin(CMD_FILTER, 256, 8388607, -8388608);
        push_bin(CMD_LEARN, 3, 1000, -1000);
        push_bin(CMD_FILTER, 3, 1000, -1000);
        push_bin(CMD_FILTER, 3, 400, 300);
        push_bin(CMD_LEARN, 257, 8388607, 8388607);
        push_bin(CMD_FILTER, 257, -5, 7);
        push_bin(CMD_FILTER, 511, -8388608, -8388608);
        push_bin(CMD_LEARN, 256, -8388608, -8388608);
        push_bin(CMD_FILTER, 256, 8388607, 8388607);
        push_bin(CMD_FILTER, 256, -1, 1);
        wait_idle();

        // zero count divides as one, table saturation, oversized gain floor
        write_reg(CFG_FRAME_COUNT, 0);
        write_reg(CFG_GAIN_FLOOR, 17'h1FFFF);
        write_reg(CFG_POWER_FLOOR, 48'd1000);
        for (k = 0; k < 2100000; k += 300000)
            push_bin(CMD_LEARN, 5, -8388608, -8388608);
        push_bin(CMD_FILTER, 5, -8388608, 8388607);
        push_bin(CMD_FILTER, 6, 10, 10);
        push_bin(CMD_FILTER, 6, 30, 10);
        push_bin(CMD_FILTER, 6, -3, 2);
        wait_idle();

        write_reg(CFG_FRAME_COUNT, 1);
        write_reg(CFG_GAIN_FLOOR, 0);
        write_reg(CFG_POWER_FLOOR, 0);
        run_phase(0, 0, 200);

        write_reg(CFG_FRAME_COUNT, 64);
        write_reg(CFG_GAIN_FLOOR, 65536);
        run_phase(56, 0, 150);

        write_reg(CFG_FRAME_COUNT, 127);
        write_reg(CFG_GAIN_FLOOR, 3277);
        write_reg(CFG_POWER_FLOOR, 48'hFFFF_FFFF_FFFF);
        run_phase(0, 56, 150);

        write_reg(CFG_FRAME_COUNT, 20);
        write_reg(CFG_GAIN_FLOOR, 6554);
        write_reg(CFG_POWER_FLOOR, 48'd1 << 30);
        run_phase(25, 25, 200);

        write_reg(CFG_FRAME_COUNT, 7'($urandom_range(1, 64)));
        write_reg(CFG_GAIN_FLOOR, 17'($urandom_range(65536)));
        write_reg(CFG_POWER_FLOOR, 48'($urandom_range(1 << 20)));
        run_phase(0, 0, 200);

        write_reg(CFG_FRAME_COUNT, 3);
        write_reg(CFG_GAIN_FLOOR, 0);
        write_reg(CFG_POWER_FLOOR, 0);
        run_phase(56, 56, 180);

        $display("sent %0d bin items, checked %0d filtered results", sent_items,
                 filtered_seen);
        $display("covered learn saturation, zero power, out of range bins, clamps");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
